// ===== rtl/core/lnf_pkg.sv =====
// Shared constants and types for the newline line framer.
`timescale 1ns / 1ps
`default_nettype none
package lnf_pkg;

    // Longest line that is kept, newline excluded.
    localparam int MAX_CHARS = 18;
    localparam int CNT_W     = 5;
    localparam int ADDR_W    = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1;
    localparam int BYTE_W    = 8;

    localparam logic [BYTE_W-1:0] NEWLINE_CODE = 8'd10;
    localparam logic [CNT_W-1:0]  MAX_COUNT    = CNT_W'(MAX_CHARS);

    // Sequencer states.
    typedef enum logic {
        ST_COLLECT,
        ST_EMIT
    } lnf_state_t;

    // Write request into the line store.
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] data;
    } lnf_store_wr_t;

endpackage
`default_nettype wire

// ===== rtl/core/lnf_line_store.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
`timescale 1ns / 1ps
`default_nettype none
module lnf_line_store #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 18,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]       rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Entries are written one at a time.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Read data is registered and appears in the cycle after the address; addresses past the end read as zero.
    always_ff @(posedge aclk) begin
        if (32'(rd_addr) < DEPTH) begin
            rd_data_reg <= mem_reg[rd_addr];
        end else begin
            rd_data_reg <= '0;
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

// ===== rtl/core/newline_line_framer.sv =====
// Top level of the newline line framer: byte collection and line emission.
//
// Usage: received bytes enter one word at a time on the s_ channel
// (s_valid, s_ready, s_rx_byte). Ordinary characters are stored in an
// 18-entry line store and produce no output. A newline (10) starts the
// emission of the stored line on the m_ channel: the characters in order
// with m_byte_index counting from 0, then the newline with m_last high.
// A line longer than 18 characters is dropped, and every byte up to and
// including the next newline is discarded without output.
// Timing: an ordinary byte is stored as it is taken. A newline after n stored
// characters occupies the block for n+1 output words, one per cycle when
// the receiver keeps m_ready high; a single index counter walks the store
// and s_ready is low until the newline word has been loaded. The output
// register lets the last word wait while new bytes are already collected.
// Reset (aresetn low, synchronous) empties the line, leaves discard mode
// and drops any output word. When the receiver stalls, the current word
// is held stable and the walk through the store pauses.
`timescale 1ns / 1ps
`default_nettype none
module newline_line_framer (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [lnf_pkg::BYTE_W-1:0]  s_rx_byte,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic [lnf_pkg::BYTE_W-1:0]       m_line_byte,
    output logic [lnf_pkg::CNT_W-1:0]        m_byte_index,
    output logic                             m_last
);
    import lnf_pkg::*;

    lnf_state_t        state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic              discard_reg, discard_next;
    logic              m_valid_reg, m_valid_next;
    logic [BYTE_W-1:0] m_byte_reg, m_byte_next;
    logic [CNT_W-1:0]  m_index_reg, m_index_next;
    logic              m_last_reg, m_last_next;

    lnf_store_wr_t     store_wr;
    logic [BYTE_W-1:0] store_rd_data;
    logic              in_fire;
    logic              out_free;
    logic              is_newline;

    // The store is read ahead, at the index the walk moves to next.
    lnf_line_store #(
        .WIDTH  (BYTE_W),
        .DEPTH  (MAX_CHARS),
        .ADDR_W (ADDR_W)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (store_wr.en),
        .wr_addr (store_wr.addr),
        .wr_data (store_wr.data),
        .rd_addr (idx_next[ADDR_W-1:0]),
        .rd_data (store_rd_data)
    );

    assign s_ready    = (state_reg == ST_COLLECT);
    assign in_fire    = s_valid && s_ready;
    assign out_free   = !m_valid_reg || m_ready;
    assign is_newline = (s_rx_byte == NEWLINE_CODE);

    // State and output registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_COLLECT;
            count_reg   <= '0;
            idx_reg     <= '0;
            discard_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            idx_reg     <= idx_next;
            discard_reg <= discard_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_byte_reg  <= m_byte_next;
        m_index_reg <= m_index_next;
        m_last_reg  <= m_last_next;
    end

    // Sequencer: collect bytes, then walk the store one word per cycle while the output is free.
    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        discard_next  = discard_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_byte_next   = m_byte_reg;
        m_index_next  = m_index_reg;
        m_last_next   = m_last_reg;
        store_wr.en   = 1'b0;
        store_wr.addr = count_reg[ADDR_W-1:0];
        store_wr.data = s_rx_byte;

        case (state_reg)
            ST_COLLECT: begin
                if (in_fire) begin
                    if (discard_reg) begin
                        // Drop everything up to and including the newline.
                        if (is_newline) begin
                            discard_next = 1'b0;
                        end
                    end else if (!is_newline) begin
                        if (count_reg < MAX_COUNT) begin
                            store_wr.en = 1'b1;
                            count_next  = count_reg + CNT_W'(1);
                        end else begin
                            // Overflow: the line is lost.
                            count_next   = '0;
                            discard_next = 1'b1;
                        end
                    end else begin
                        idx_next   = '0;
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_index_next = idx_reg;
                    if (idx_reg < count_reg) begin
                        m_byte_next = store_rd_data;
                        m_last_next = 1'b0;
                        idx_next    = idx_reg + CNT_W'(1);
                    end else begin
                        // Closing newline ends the line.
                        m_byte_next = NEWLINE_CODE;
                        m_last_next = 1'b1;
                        count_next  = '0;
                        state_next  = ST_COLLECT;
                    end
                end
            end
            default: begin
                state_next = ST_COLLECT;
            end
        endcase
    end

    assign m_valid      = m_valid_reg;
    assign m_line_byte  = m_byte_reg;
    assign m_byte_index = m_index_reg;
    assign m_last       = m_last_reg;

endmodule
`default_nettype wire
